// ===== sv/mscl_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor speed control loop package
// Shared types, constants and arithmetic helpers for the speed controller.
// ----------------------------------------------------------------------------
package mscl_pkg;

  // Fixed widths of the arithmetic unit.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MUL_W   = 33;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned ACC_W   = 66;
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned PWR_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Smoothing weight is Q1.16, independent of the speed format.
  localparam int unsigned ALPHA_BITS = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  localparam logic signed [MUL_W-1:0] PWR_MAX = 33'sd100;
  localparam logic signed [MUL_W-1:0] PWR_MIN = -33'sd100;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RAW  = 2'd1,
    OP_REF  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_CLOSED = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA    = 3'd0,
    CFG_GAIN     = 3'd1,
    CFG_OUT_PRV1 = 3'd2,
    CFG_OUT_PRV2 = 3'd3,
    CFG_ERR_NOW  = 3'd4,
    CFG_ERR_PRV1 = 3'd5,
    CFG_ERR_PRV2 = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_RAW_MUL,
    ST_RAW_SAT,
    ST_SM_MUL0,
    ST_SM_MUL1,
    ST_SM_ACC,
    ST_SM_DONE,
    ST_ERR,
    ST_C_MUL0,
    ST_C_MUL1,
    ST_C_MUL2,
    ST_C_MUL3,
    ST_C_MUL4,
    ST_C_ACC,
    ST_C_DONE
  } st_e;

  // The result beat waits in its own state; kept outside the enum above so
  // the sixteen states fill four bits exactly.
  typedef struct packed {
    st_e  st;
    logic load_out;
    logic take_tick;
    logic take_raw;
    logic take_ref;
  } ctl_t;

  typedef struct packed {
    logic        [ALPHA_W-1:0] alpha;
    logic signed [DATA_W-1:0]  gain;
    logic signed [DATA_W-1:0]  out_prv1;
    logic signed [DATA_W-1:0]  out_prv2;
    logic signed [DATA_W-1:0]  err_now;
    logic signed [DATA_W-1:0]  err_prv1;
    logic signed [DATA_W-1:0]  err_prv2;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    alpha:    17'd32768,
    gain:     32'sd571910,
    out_prv1: 32'sd127134,
    out_prv2: -32'sd61595,
    err_now:  32'sd853006,
    err_prv1: -32'sd1652278,
    err_prv2: 32'sd800119
  };

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:DATA_W-1]) | ~(|v[ACC_W-1:DATA_W-1]);
    if (fits) begin
      return v[DATA_W-1:0];
    end
    return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub32(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) begin
      return d[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return d[DATA_W-1:0];
  endfunction

  function automatic logic signed [PWR_W-1:0] clamp_pwr(input logic signed [MUL_W-1:0] v);
    if (v > PWR_MAX) begin
      return 8'sd100;
    end
    if (v < PWR_MIN) begin
      return -8'sd100;
    end
    return v[PWR_W-1:0];
  endfunction

endpackage

// ===== sv/mscl_seq.sv =====
// ----------------------------------------------------------------------------
// Motor speed control sequencer
// Steps the shared multiply-accumulate unit through one tick and tracks the
// drive mode set by the command items.
// ----------------------------------------------------------------------------
module mscl_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mscl_pkg::ctl_t     ctl_o
);

  mscl_pkg::st_e   st_q, st_d;
  logic            wait_q, wait_d;
  logic            ov_q, ov_d;
  mscl_pkg::mode_e mode_q, mode_d;
  logic            accept;
  logic            load_out;
  mscl_pkg::op_e   op;

  assign op     = mscl_pkg::op_e'(opcode_i);
  assign accept = in_valid_i && in_ready_o;
  // A finished result moves to the output register once that register is
  // empty or its beat is taken in the same cycle.
  assign load_out = wait_q && (!ov_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mscl_pkg::ST_IDLE;
      wait_q <= 1'b0;
      ov_q   <= 1'b0;
      mode_q <= mscl_pkg::MODE_IDLE;
    end else begin
      st_q   <= st_d;
      wait_q <= wait_d;
      ov_q   <= ov_d;
      mode_q <= mode_d;
    end
  end

  // Next state.
  always_comb begin
    st_d   = st_q;
    wait_d = wait_q;
    ov_d   = ov_q;
    mode_d = mode_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    if (load_out) begin
      ov_d = 1'b1;
    end
    if (wait_q) begin
      if (load_out) begin
        wait_d = 1'b0;
      end
    end else begin
      case (st_q)
        mscl_pkg::ST_IDLE: begin
          if (accept) begin
            case (op)
              mscl_pkg::OP_TICK: st_d = mscl_pkg::ST_DELTA;
              mscl_pkg::OP_RAW:  mode_d = mscl_pkg::MODE_RAW;
              mscl_pkg::OP_REF:  mode_d = mscl_pkg::MODE_CLOSED;
              default: ;
            endcase
          end
        end
        mscl_pkg::ST_DELTA:   st_d = mscl_pkg::ST_RAW_MUL;
        mscl_pkg::ST_RAW_MUL: st_d = mscl_pkg::ST_RAW_SAT;
        mscl_pkg::ST_RAW_SAT: st_d = mscl_pkg::ST_SM_MUL0;
        mscl_pkg::ST_SM_MUL0: st_d = mscl_pkg::ST_SM_MUL1;
        mscl_pkg::ST_SM_MUL1: st_d = mscl_pkg::ST_SM_ACC;
        mscl_pkg::ST_SM_ACC:  st_d = mscl_pkg::ST_SM_DONE;
        mscl_pkg::ST_SM_DONE: begin
          case (mode_q)
            mscl_pkg::MODE_CLOSED: st_d = mscl_pkg::ST_ERR;
            mscl_pkg::MODE_RAW: begin
              st_d   = mscl_pkg::ST_IDLE;
              wait_d = 1'b1;
            end
            default: st_d = mscl_pkg::ST_IDLE;
          endcase
        end
        mscl_pkg::ST_ERR:    st_d = mscl_pkg::ST_C_MUL0;
        mscl_pkg::ST_C_MUL0: st_d = mscl_pkg::ST_C_MUL1;
        mscl_pkg::ST_C_MUL1: st_d = mscl_pkg::ST_C_MUL2;
        mscl_pkg::ST_C_MUL2: st_d = mscl_pkg::ST_C_MUL3;
        mscl_pkg::ST_C_MUL3: st_d = mscl_pkg::ST_C_MUL4;
        mscl_pkg::ST_C_MUL4: st_d = mscl_pkg::ST_C_ACC;
        mscl_pkg::ST_C_ACC:  st_d = mscl_pkg::ST_C_DONE;
        mscl_pkg::ST_C_DONE: begin
          st_d   = mscl_pkg::ST_IDLE;
          wait_d = 1'b1;
        end
        default: st_d = mscl_pkg::ST_IDLE;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    in_ready_o        = (st_q == mscl_pkg::ST_IDLE) && !wait_q;
    out_valid_o       = ov_q;
    ctl_o.st          = st_q;
    ctl_o.load_out    = load_out;
    ctl_o.take_tick   = 1'b0;
    ctl_o.take_raw    = 1'b0;
    ctl_o.take_ref    = 1'b0;
    if (in_valid_i && (st_q == mscl_pkg::ST_IDLE) && !wait_q) begin
      case (op)
        mscl_pkg::OP_TICK: ctl_o.take_tick = 1'b1;
        mscl_pkg::OP_RAW:  ctl_o.take_raw  = 1'b1;
        mscl_pkg::OP_REF:  ctl_o.take_ref  = 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mscl_dp.sv =====
// ----------------------------------------------------------------------------
// Motor speed control datapath
// One shared 33x33 multiplier, a 66-bit accumulator and a saturating
// subtractor, with the speed and compensator state registers and the
// result register.
// ----------------------------------------------------------------------------
module mscl_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mscl_pkg::ctl_t        ctl_i,
  input  mscl_pkg::cfg_t        cfg_i,
  input  logic signed [31:0]    tacho_count_i,
  input  logic signed [7:0]     raw_power_i,
  input  logic signed [31:0]    speed_reference_i,
  output logic signed [7:0]     motor_power_o,
  output logic signed [31:0]    measured_speed_o
);

  localparam int unsigned AW = mscl_pkg::ACC_W;
  localparam int unsigned MW = mscl_pkg::MUL_W;
  localparam int unsigned DW = mscl_pkg::DATA_W;
  localparam int unsigned PW = mscl_pkg::PROD_W;

  localparam logic signed [AW-1:0] RND_FRAC  = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] RND_ALPHA = AW'(1) << (mscl_pkg::ALPHA_BITS - 1);

  // State with a defined reset value.
  logic signed [DW-1:0] last_count_q, smoothed_q, target_q;
  logic signed [DW-1:0] err1_q, err2_q, out1_q, out2_q;
  logic signed [7:0]    held_q;

  // Working registers.
  logic signed [DW-1:0] count_q, diff_q, raw_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic signed [7:0]    power_q;

  // Result register, loaded when the finished beat moves out.
  logic signed [7:0]    out_pwr_q;
  logic signed [DW-1:0] out_spd_q;

  logic signed [DW-1:0] sub_a, sub_b, sub_res;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] product;
  logic [mscl_pkg::ALPHA_W-1:0] alpha_eff, alpha_rest;
  logic signed [AW-1:0] acc_sum, sm_shift, y_shift;
  logic signed [DW-1:0] y_new;
  logic        [DW:0]   y_abs, y_abs_shr;
  logic signed [DW:0]   y_trunc;

  // Weights above one count as exactly one.
  assign alpha_eff  = cfg_i.alpha[mscl_pkg::ALPHA_W-1] ? mscl_pkg::ALPHA_ONE : cfg_i.alpha;
  assign alpha_rest = mscl_pkg::ALPHA_ONE - alpha_eff;

  // Shared subtractor: count delta on a tick, speed error in closed loop.
  always_comb begin
    if (ctl_i.st == mscl_pkg::ST_DELTA) begin
      sub_a = count_q;
      sub_b = last_count_q;
    end else begin
      sub_a = target_q;
      sub_b = smoothed_q;
    end
    sub_res = mscl_pkg::sat_sub32(sub_a, sub_b);
  end

  always_comb begin
    case (ctl_i.st)
      mscl_pkg::ST_RAW_MUL: begin
        mul_a = {diff_q[DW-1], diff_q};
        mul_b = {cfg_i.gain[DW-1], cfg_i.gain};
      end
      mscl_pkg::ST_SM_MUL0: begin
        mul_a = {raw_q[DW-1], raw_q};
        mul_b = {{(MW - mscl_pkg::ALPHA_W){1'b0}}, alpha_eff};
      end
      mscl_pkg::ST_SM_MUL1: begin
        mul_a = {smoothed_q[DW-1], smoothed_q};
        mul_b = {{(MW - mscl_pkg::ALPHA_W){1'b0}}, alpha_rest};
      end
      mscl_pkg::ST_C_MUL0: begin
        mul_a = {cfg_i.out_prv1[DW-1], cfg_i.out_prv1};
        mul_b = {out1_q[DW-1], out1_q};
      end
      mscl_pkg::ST_C_MUL1: begin
        mul_a = {cfg_i.out_prv2[DW-1], cfg_i.out_prv2};
        mul_b = {out2_q[DW-1], out2_q};
      end
      mscl_pkg::ST_C_MUL2: begin
        mul_a = {cfg_i.err_now[DW-1], cfg_i.err_now};
        mul_b = {diff_q[DW-1], diff_q};
      end
      mscl_pkg::ST_C_MUL3: begin
        mul_a = {cfg_i.err_prv1[DW-1], cfg_i.err_prv1};
        mul_b = {err1_q[DW-1], err1_q};
      end
      mscl_pkg::ST_C_MUL4: begin
        mul_a = {cfg_i.err_prv2[DW-1], cfg_i.err_prv2};
        mul_b = {err2_q[DW-1], err2_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Operands are at most 32 by 32 significant bits, so 64 product bits hold
  // every result exactly.
  assign product  = mul_a * mul_b;
  assign acc_sum  = acc_q + {{(AW - PW){prod_q[PW-1]}}, prod_q};
  assign sm_shift = acc_q >>> mscl_pkg::ALPHA_BITS;
  assign y_shift  = acc_q >>> FRAC_BITS;
  assign y_new    = mscl_pkg::sat32(y_shift);

  // Integer part of the controller output, rounded toward zero.
  always_comb begin
    y_abs     = y_new[DW-1] ? (-{y_new[DW-1], y_new}) : {y_new[DW-1], y_new};
    y_abs_shr = y_abs >> FRAC_BITS;
    y_trunc   = y_new[DW-1] ? -$signed(y_abs_shr) : $signed(y_abs_shr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      smoothed_q   <= '0;
      target_q     <= '0;
      err1_q       <= '0;
      err2_q       <= '0;
      out1_q       <= '0;
      out2_q       <= '0;
      held_q       <= '0;
    end else begin
      if (ctl_i.take_raw) begin
        held_q <= raw_power_i;
      end
      if (ctl_i.take_ref) begin
        target_q <= speed_reference_i;
      end
      if (ctl_i.st == mscl_pkg::ST_DELTA) begin
        last_count_q <= count_q;
      end
      if (ctl_i.st == mscl_pkg::ST_SM_DONE) begin
        smoothed_q <= mscl_pkg::sat32(sm_shift);
      end
      if (ctl_i.st == mscl_pkg::ST_C_DONE) begin
        out1_q <= y_new;
        out2_q <= out1_q;
        err1_q <= diff_q;
        err2_q <= err1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take_tick) begin
      count_q <= tacho_count_i;
    end
    if ((ctl_i.st == mscl_pkg::ST_DELTA) || (ctl_i.st == mscl_pkg::ST_ERR)) begin
      diff_q <= sub_res;
    end
    prod_q <= product[PW-1:0];
    if (ctl_i.st == mscl_pkg::ST_RAW_SAT) begin
      raw_q <= mscl_pkg::sat32({{(AW - PW){prod_q[PW-1]}}, prod_q});
    end
    case (ctl_i.st)
      mscl_pkg::ST_SM_MUL0: acc_q <= RND_ALPHA;
      mscl_pkg::ST_C_MUL0:  acc_q <= RND_FRAC;
      mscl_pkg::ST_SM_MUL1,
      mscl_pkg::ST_SM_ACC,
      mscl_pkg::ST_C_MUL1,
      mscl_pkg::ST_C_MUL2,
      mscl_pkg::ST_C_MUL3,
      mscl_pkg::ST_C_MUL4,
      mscl_pkg::ST_C_ACC:   acc_q <= acc_sum;
      default: ;
    endcase
    // Raw mode drives the held power; closed loop overwrites it at the end.
    if (ctl_i.st == mscl_pkg::ST_SM_DONE) begin
      power_q <= mscl_pkg::clamp_pwr({{(MW - 8){held_q[7]}}, held_q});
    end else if (ctl_i.st == mscl_pkg::ST_C_DONE) begin
      power_q <= mscl_pkg::clamp_pwr(y_trunc);
    end
    if (ctl_i.load_out) begin
      out_pwr_q <= power_q;
      out_spd_q <= smoothed_q;
    end
  end

  assign motor_power_o    = out_pwr_q;
  assign measured_speed_o = out_spd_q;

endmodule

// ===== sv/motor_speed_control_loop.sv =====
// ----------------------------------------------------------------------------
// Motor speed control loop
// Tacho-driven speed estimator and second-order IIR speed compensator for
// one motor, built around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Set-power and set-reference commands give no result. A tick holds the
// input through the speed-estimate states (delta, raw product, saturation,
// two smoothing products, accumulate, done), in closed-loop mode through
// the compensator states (error, five products, accumulate, done), and in
// raw or closed-loop mode until the result beat moves into the output
// register. That move waits only while the previous result beat still sits
// there waiting for out_ready_i. The single 33x33 multiplier and accumulator
// serve one product per cycle. No result beat is sent for a tick while the
// drive mode is idle. Configuration writes are always ready; the user must
// keep them to idle periods, which the block itself does not enforce.
module motor_speed_control_loop #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] tacho_count_i,
  input  logic signed [7:0]  raw_power_i,
  input  logic signed [31:0] speed_reference_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [7:0]  motor_power_o,
  output logic signed [31:0] measured_speed_o
);

  mscl_pkg::cfg_t cfg_q;
  mscl_pkg::ctl_t ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mscl_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mscl_pkg::cfg_idx_e'(cfg_index_i))
        mscl_pkg::CFG_ALPHA:    cfg_q.alpha    <= cfg_data_i[mscl_pkg::ALPHA_W-1:0];
        mscl_pkg::CFG_GAIN:     cfg_q.gain     <= cfg_data_i;
        mscl_pkg::CFG_OUT_PRV1: cfg_q.out_prv1 <= cfg_data_i;
        mscl_pkg::CFG_OUT_PRV2: cfg_q.out_prv2 <= cfg_data_i;
        mscl_pkg::CFG_ERR_NOW:  cfg_q.err_now  <= cfg_data_i;
        mscl_pkg::CFG_ERR_PRV1: cfg_q.err_prv1 <= cfg_data_i;
        mscl_pkg::CFG_ERR_PRV2: cfg_q.err_prv2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mscl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  mscl_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .cfg_i             (cfg_q),
    .tacho_count_i     (tacho_count_i),
    .raw_power_i       (raw_power_i),
    .speed_reference_i (speed_reference_i),
    .motor_power_o     (motor_power_o),
    .measured_speed_o  (measured_speed_o)
  );

endmodule

// ===== tb/tb_motor_speed_control_loop.sv =====
// ----------------------------------------------------------------------------
// Motor speed control loop testbench
// Drives tacho ticks and drive commands through the block under five
// register settings. Each tick that gives a result has its power and speed
// predicted and checked in order, while both channels stall at random.
// ----------------------------------------------------------------------------
module tb_motor_speed_control_loop;

  localparam int FRAC = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic signed [7:0]  pwr;
    logic signed [31:0] spd;
  } drive_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] count;
    logic signed [7:0]  pwr;
    logic signed [31:0] goal;
    logic               typed;
    logic signed [7:0]  want_pwr;
    logic signed [31:0] want_spd;
  } plan_row_t;

  localparam int PLAN_LEN = 25;
  // Rows with typed set carry the result that follows from zero speed.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{mscl_pkg::OP_TICK, 32'sd0,         8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{OP_UNUSED,         -32'sd1,        -8'sd1,   -32'sd1,        1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_RAW,  32'sd0,         8'sd100,  32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd0,         8'sd0,    32'sd0,         1'b1, 8'sd100,  32'sd0},
    '{mscl_pkg::OP_RAW,  32'sd0,         8'sd127,  32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd0,         8'sd0,    32'sd0,         1'b1, 8'sd100,  32'sd0},
    '{mscl_pkg::OP_RAW,  32'sd0,         8'sh80,   32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd0,         8'sd0,    32'sd0,         1'b1, -8'sd100, 32'sd0},
    '{mscl_pkg::OP_RAW,  32'sd0,         -8'sd100, 32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd0,         8'sd0,    32'sd0,         1'b1, -8'sd100, 32'sd0},
    '{mscl_pkg::OP_RAW,  32'sd0,         8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd0,         8'sd0,    32'sd0,         1'b1, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sh7fff_ffff, 8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sh8000_0000, 8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_REF,  32'sd0,         8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sh8000_0000, 8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_REF,  32'sd0,         8'sd0,    32'sh7fff_ffff, 1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sh8000_0001, 8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_REF,  32'sd0,         8'sd0,    32'sh8000_0000, 1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd0,         8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd100,       8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_RAW,  32'sd0,         8'sd55,   32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd103,       8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_REF,  32'sd0,         8'sd0,    32'sh0001_0000, 1'b0, 8'sd0,    32'sd0},
    '{mscl_pkg::OP_TICK, 32'sd110,       8'sd0,    32'sd0,         1'b0, 8'sd0,    32'sd0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         opcode_i = '0;
  logic signed [31:0] tacho_count_i = '0;
  logic signed [7:0]  raw_power_i = '0;
  logic signed [31:0] speed_reference_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [7:0]  motor_power_o;
  logic signed [31:0] measured_speed_o;

  motor_speed_control_loop #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers.
  mscl_pkg::cfg_t  coefs;
  int              prev_count;
  int              speed_est;
  int              err_hist [2];
  int              y_hist [2];
  mscl_pkg::mode_e drive_state;
  logic signed [7:0] held_pwr;
  int              speed_goal;

  drive_t pending_drive [$];
  int     send_gap_pct = 10;
  int     stall_pct = 60;
  int     errors = 0;
  int     results_seen = 0;
  int     ticks_in = 0;
  int     cmds_in = 0;
  int     ignored_in = 0;

  task automatic flag(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic int clip32(input logic signed [127:0] v);
    if (v > 128'sh7fff_ffff) return 32'sh7fff_ffff;
    if (v < -128'sh8000_0000) return 32'sh8000_0000;
    return int'(v[31:0]);
  endfunction

  function automatic logic signed [7:0] limit_power(input longint v);
    if (v > 100) return 8'sd100;
    if (v < -100) return -8'sd100;
    return v[7:0];
  endfunction

  // Advances the predictor by one accepted input beat; returns 1 when the
  // beat produces a result beat.
  function automatic bit step_motor(input logic [1:0] op, input int count,
                                    input logic signed [7:0] pwr, input int goal,
                                    output drive_t res);
    longint a;
    longint sum64;
    longint mag;
    int raw;
    int err;
    int y;
    logic signed [127:0] acc;
    res = '0;
    case (op)
      mscl_pkg::OP_RAW: begin
        drive_state = mscl_pkg::MODE_RAW;
        held_pwr = pwr;
        return 1'b0;
      end
      mscl_pkg::OP_REF: begin
        drive_state = mscl_pkg::MODE_CLOSED;
        speed_goal = goal;
        return 1'b0;
      end
      mscl_pkg::OP_TICK: ;
      default: return 1'b0;
    endcase

    raw = clip32(longint'(clip32(longint'(count) - longint'(prev_count)))
                 * longint'(coefs.gain));
    prev_count = count;
    a = (coefs.alpha > mscl_pkg::ALPHA_ONE) ? longint'(mscl_pkg::ALPHA_ONE)
                                            : longint'(coefs.alpha);
    sum64 = longint'(raw) * a + longint'(speed_est) * (64'sd65536 - a) + 64'sd32768;
    speed_est = clip32(sum64 >>> 16);

    if (drive_state == mscl_pkg::MODE_CLOSED) begin
      err = clip32(longint'(speed_goal) - longint'(speed_est));
      acc = '0;
      acc += longint'(coefs.out_prv1) * longint'(y_hist[0]);
      acc += longint'(coefs.out_prv2) * longint'(y_hist[1]);
      acc += longint'(coefs.err_now) * longint'(err);
      acc += longint'(coefs.err_prv1) * longint'(err_hist[0]);
      acc += longint'(coefs.err_prv2) * longint'(err_hist[1]);
      y = clip32((acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC);
      err_hist[1] = err_hist[0];
      err_hist[0] = err;
      y_hist[1] = y_hist[0];
      y_hist[0] = y;
      // Power is the integer part, truncated toward zero.
      mag = (y >= 0) ? (longint'(y) >>> FRAC) : -((-longint'(y)) >>> FRAC);
      res.pwr = limit_power(mag);
    end else if (drive_state == mscl_pkg::MODE_RAW) begin
      res.pwr = limit_power(longint'(held_pwr));
    end else begin
      return 1'b0;
    end
    res.spd = speed_est;
    return 1'b1;
  endfunction

  task automatic issue(input logic [1:0] op, input int count, input logic signed [7:0] pwr,
                       input int goal, input logic typed, input drive_t typed_res);
    drive_t res;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    tacho_count_i <= count;
    raw_power_i <= pwr;
    speed_reference_i <= goal;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == mscl_pkg::OP_TICK) ticks_in++;
    else if (op == OP_UNUSED) ignored_in++;
    else cmds_in++;
    if (step_motor(op, count, pwr, goal, res)) begin
      pending_drive.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic gap();
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mscl_pkg::CFG_ALPHA:    coefs.alpha = data[16:0];
      mscl_pkg::CFG_GAIN:     coefs.gain = data;
      mscl_pkg::CFG_OUT_PRV1: coefs.out_prv1 = data;
      mscl_pkg::CFG_OUT_PRV2: coefs.out_prv2 = data;
      mscl_pkg::CFG_ERR_NOW:  coefs.err_now = data;
      mscl_pkg::CFG_ERR_PRV1: coefs.err_prv1 = data;
      mscl_pkg::CFG_ERR_PRV2: coefs.err_prv2 = data;
      default: ;
    endcase
  endtask

  // A tick in idle mode gives no result beat, so the block may still be busy
  // once the queue is empty; wait out a full tick before touching registers.
  task automatic load_coefs(input logic [31:0] alpha_word, input logic [31:0] gain,
                            input logic [31:0] c1, input logic [31:0] c2,
                            input logic [31:0] e0, input logic [31:0] e1,
                            input logic [31:0] e2);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(mscl_pkg::CFG_ALPHA, alpha_word);
    write_reg(mscl_pkg::CFG_GAIN, gain);
    write_reg(mscl_pkg::CFG_OUT_PRV1, c1);
    write_reg(mscl_pkg::CFG_OUT_PRV2, c2);
    write_reg(mscl_pkg::CFG_ERR_NOW, e0);
    write_reg(mscl_pkg::CFG_ERR_PRV1, e1);
    write_reg(mscl_pkg::CFG_ERR_PRV2, e2);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly ticks with small count steps, so the loop sees plausible motion;
  // some full-range counts, commands and ignored opcodes mixed in.
  task automatic run_random(input int n);
    int done_items;
    int roll;
    int count;
    int goal;
    logic [1:0] op;
    logic signed [7:0] pwr;
    done_items = 0;
    while (done_items < n) begin
      roll = $urandom_range(99);
      count = $urandom;
      pwr = 8'($urandom);
      goal = $urandom;
      if (roll < 68) begin
        op = mscl_pkg::OP_TICK;
        if ($urandom_range(19) != 0) count = prev_count + $urandom_range(40) - 20;
      end else if (roll < 80) begin
        op = mscl_pkg::OP_RAW;
        if ($urandom_range(7) != 0) pwr = 8'($urandom_range(200) - 100);
      end else if (roll < 94) begin
        op = mscl_pkg::OP_REF;
        if ($urandom_range(7) != 0) goal = $urandom_range(32'h0028_0000) - 32'h0014_0000;
      end else begin
        op = OP_UNUSED;
      end
      if (op != OP_UNUSED) done_items++;
      if (done_items == 10 || $urandom_range(59) == 0) drain();
      gap();
      issue(op, count, pwr, goal, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_drive.size() == 0) begin
        flag($sformatf("result beat (%0d, %0d) with nothing pending",
                       motor_power_o, measured_speed_o));
      end else begin
        want = pending_drive.pop_front();
        results_seen++;
        if (motor_power_o !== want.pwr) begin
          flag($sformatf("motor_power %0d, want %0d", motor_power_o, want.pwr));
        end
        if (measured_speed_o !== want.spd) begin
          flag($sformatf("measured_speed %0d, want %0d", measured_speed_o, want.spd));
        end
      end
    end
  end

  initial begin
    drive_t typed_res;
    coefs = mscl_pkg::CFG_RESET;
    prev_count = 0;
    speed_est = 0;
    err_hist = '{0, 0};
    y_hist = '{0, 0};
    drive_state = mscl_pkg::MODE_IDLE;
    held_pwr = '0;
    speed_goal = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      typed_res.pwr = PLAN[i].want_pwr;
      typed_res.spd = PLAN[i].want_spd;
      issue(PLAN[i].op, PLAN[i].count, PLAN[i].pwr, PLAN[i].goal, PLAN[i].typed,
            typed_res);
    end
    run_random(120);

    // Alpha of zero freezes the speed estimate; coefficients at the limits.
    load_coefs(32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
               32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    run_random(90);

    // Alpha above one, with stray upper bits, and the opposite limits.
    send_gap_pct = 60;
    stall_pct = 10;
    load_coefs(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
               32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    write_reg(CFG_UNUSED, $urandom);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    run_random(90);

    load_coefs(32'h0001_0000 | ($urandom & 32'hfffe_0000), $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
    run_random(90);

    send_gap_pct = 0;
    stall_pct = 0;
    load_coefs({15'($urandom), mscl_pkg::CFG_RESET.alpha}, mscl_pkg::CFG_RESET.gain,
               mscl_pkg::CFG_RESET.out_prv1, mscl_pkg::CFG_RESET.out_prv2,
               mscl_pkg::CFG_RESET.err_now, mscl_pkg::CFG_RESET.err_prv1,
               mscl_pkg::CFG_RESET.err_prv2);
    run_random(110);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d ticks, %0d commands and %0d ignored beats over five settings.",
             ticks_in, cmds_in, ignored_in);
    $display("Checked %0d result beats; %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
